/* src/mptl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mptl_pkg
// Shared widths, constants and types for the three-length max-pieces block.
// ----------------------------------------------------------------------------
package mptl_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int DEPTH    = MAX_LEN + 1;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int LEN_W    = 13;
    localparam int CMP_W    = (ADDR_W > LEN_W) ? ADDR_W : LEN_W;
    localparam int CNT_W    = 14;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 16;

    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic signed [CNT_W-1:0] count_t;

    localparam count_t UNREACHABLE = -14'sd1;
    localparam count_t COUNT_MAX   = 14'sd8191;
    localparam count_t COUNT_ZERO  = 14'sd0;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        count_t data;
    } wr_req_t;

    typedef struct packed {
        addr_t a;
        addr_t b;
        addr_t c;
    } rd_addr_t;

    typedef struct packed {
        count_t a;
        count_t b;
        count_t c;
    } rd_data_t;

endpackage

/* src/mptl_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mptl_table
// Best-count table: two copies sharing one write port, three registered reads.
// ----------------------------------------------------------------------------
module mptl_table
(
    input  logic               clk,
    input  mptl_pkg::wr_req_t  wr,
    input  mptl_pkg::rd_addr_t rd_addr,
    output mptl_pkg::rd_data_t rd_data
);

    mptl_pkg::count_t   mem_ab [0:mptl_pkg::DEPTH-1];
    mptl_pkg::count_t   mem_c  [0:mptl_pkg::DEPTH-1];
    mptl_pkg::rd_data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_ab[wr.addr] <= wr.data;
            mem_c[wr.addr]  <= wr.data;
        end
        rd_data_reg.a <= mem_ab[rd_addr.a];
        rd_data_reg.b <= mem_ab[rd_addr.b];
        rd_data_reg.c <= mem_c[rd_addr.c];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/max_pieces_three_lengths_dp_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pieces_three_lengths_dp_top
// Greatest count of pieces of three given lengths that sum to a total.
//
// channel | dir | tdata fields (low bit up)
// --------+-----+--------------------------------------------------------
// s_*     | in  | total_length[12:0] piece_a[25:13] piece_b[38:26]
//         |     | piece_c[51:39], zero pad [55:52]
// m_*     | out | max_pieces[13:0] (signed, -1 = no cut), zero pad [15:14]
//
// Each item walks positions 0 through total_length before its result: the table
// walk issues one position per cycle against the table's registered reads.
// A total above MAX_LEN skips the walk and goes to the done state with -1.
// A held result does not block the next item; a finished result waits in
// the done state while the output register is still full.
// Reset clears control only; table contents need no clearing.
// ----------------------------------------------------------------------------
module max_pieces_three_lengths_dp_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mptl_pkg::S_DATA_W-1:0]   s_tdata,   // total_length, piece_a, piece_b, piece_c
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mptl_pkg::M_DATA_W-1:0]   m_tdata    // max_pieces
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    function automatic mptl_pkg::count_t offer(input logic en, input mptl_pkg::count_t v);
        mptl_pkg::count_t r;
        if (!en || v == mptl_pkg::UNREACHABLE)
            r = mptl_pkg::UNREACHABLE;
        else if (v == mptl_pkg::COUNT_MAX)
            r = mptl_pkg::COUNT_MAX;
        else
            r = v + 14'sd1;
        return r;
    endfunction

    logic [1:0]              state_reg, state_next;
    mptl_pkg::addr_t         total_reg, total_next;
    mptl_pkg::len_t          pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next;
    mptl_pkg::addr_t         iss_pos_reg, iss_pos_next;
    logic                    iss_on_reg, iss_on_next;
    logic                    s2_valid_reg, s2_valid_next;
    mptl_pkg::addr_t         s2_pos_reg, s2_pos_next;
    logic [2:0]              s2_en_reg, s2_en_next;
    mptl_pkg::count_t        last_val_reg, last_val_next;
    mptl_pkg::count_t        res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    mptl_pkg::count_t        m_data_reg, m_data_next;

    mptl_pkg::len_t          in_total, in_pa, in_pb, in_pc;
    logic [mptl_pkg::CMP_W-1:0] in_total_ext, iss_ext, diff_a, diff_b, diff_c;
    logic                    accept, over, iss_last, s2_last;
    logic                    en_a, en_b, en_c;
    mptl_pkg::count_t        op_a, op_b, op_c, cand_a, cand_b, cand_c, max_ab, best, val;
    mptl_pkg::wr_req_t       wr;
    mptl_pkg::rd_addr_t      rd_addr;
    mptl_pkg::rd_data_t      rd_data;

    mptl_table u_table
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_total     = s_tdata[12:0];
    assign in_pa        = s_tdata[25:13];
    assign in_pb        = s_tdata[38:26];
    assign in_pc        = s_tdata[51:39];
    assign in_total_ext = mptl_pkg::CMP_W'(in_total);
    assign over         = in_total_ext > mptl_pkg::CMP_W'(mptl_pkg::MAX_LEN);
    assign s_tready     = (state_reg == ST_IDLE);
    assign accept       = s_tvalid && s_tready;

    // issue stage: read t-a, t-b, t-c for position t
    always_comb
    begin
        iss_ext   = mptl_pkg::CMP_W'(iss_pos_reg);
        en_a      = (pa_reg != '0) && (mptl_pkg::CMP_W'(pa_reg) <= iss_ext);
        en_b      = (pb_reg != '0) && (mptl_pkg::CMP_W'(pb_reg) <= iss_ext);
        en_c      = (pc_reg != '0) && (mptl_pkg::CMP_W'(pc_reg) <= iss_ext);
        diff_a    = iss_ext - mptl_pkg::CMP_W'(pa_reg);
        diff_b    = iss_ext - mptl_pkg::CMP_W'(pb_reg);
        diff_c    = iss_ext - mptl_pkg::CMP_W'(pc_reg);
        rd_addr.a = diff_a[mptl_pkg::ADDR_W-1:0];
        rd_addr.b = diff_b[mptl_pkg::ADDR_W-1:0];
        rd_addr.c = diff_c[mptl_pkg::ADDR_W-1:0];
        iss_last  = (iss_pos_reg == total_reg);
    end

    // update stage; a length of 1 reads the entry written on the same edge
    always_comb
    begin
        op_a    = (pa_reg == mptl_pkg::LEN_W'(1)) ? last_val_reg : rd_data.a;
        op_b    = (pb_reg == mptl_pkg::LEN_W'(1)) ? last_val_reg : rd_data.b;
        op_c    = (pc_reg == mptl_pkg::LEN_W'(1)) ? last_val_reg : rd_data.c;
        cand_a  = offer(s2_en_reg[2], op_a);
        cand_b  = offer(s2_en_reg[1], op_b);
        cand_c  = offer(s2_en_reg[0], op_c);
        max_ab  = (cand_a > cand_b) ? cand_a : cand_b;
        best    = (max_ab > cand_c) ? max_ab : cand_c;
        val     = (s2_pos_reg == '0) ? mptl_pkg::COUNT_ZERO : best;
        s2_last = (s2_pos_reg == total_reg);
        wr.en   = s2_valid_reg;
        wr.addr = s2_pos_reg;
        wr.data = val;
    end

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        pc_next       = pc_reg;
        iss_pos_next  = iss_pos_reg;
        iss_on_next   = iss_on_reg;
        s2_valid_next = 1'b0;
        s2_pos_next   = iss_pos_reg;
        s2_en_next    = {en_a, en_b, en_c};
        last_val_next = s2_valid_reg ? val : last_val_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pa_next    = in_pa;
                    pb_next    = in_pb;
                    pc_next    = in_pc;
                    total_next = in_total_ext[mptl_pkg::ADDR_W-1:0];
                    if (over)
                    begin
                        res_next   = mptl_pkg::UNREACHABLE;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        iss_pos_next = '0;
                        iss_on_next  = 1'b1;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (iss_on_reg)
                begin
                    s2_valid_next = 1'b1;
                    if (iss_last)
                        iss_on_next = 1'b0;
                    else
                        iss_pos_next = iss_pos_reg + mptl_pkg::ADDR_W'(1);
                end
                if (s2_valid_reg && s2_last)
                begin
                    res_next   = val;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iss_on_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_on_reg   <= iss_on_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        pc_reg       <= pc_next;
        iss_pos_reg  <= iss_pos_next;
        s2_pos_reg   <= s2_pos_next;
        s2_en_reg    <= s2_en_next;
        last_val_reg <= last_val_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mptl_pkg::M_DATA_W - mptl_pkg::CNT_W){1'b0}}, m_data_reg};

endmodule

/* src/mptl_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mptl_check
// Port-level checks for the max-pieces block, bound to the top level.
// ----------------------------------------------------------------------------
module mptl_check
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mptl_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mptl_pkg::M_DATA_W-1:0] m_tdata
);

    // output holds while stalled
    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // result is -1 or a count no larger than the table, pad bits zero
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:14] == 2'b00) &&
                     ((m_tdata[13:0] == 14'h3FFF) ||
                      (m_tdata[13:0] <= 14'(mptl_pkg::MAX_LEN))))
        else $error("result out of range");

    // no transfer, an oversized total included, reaches a result in the next cycle
    a_over: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared one cycle after transfer");

endmodule

bind max_pieces_three_lengths_dp_top mptl_check u_mptl_check (.*);
